[rtl/pftb_pkg.sv]
// ----------------------------------------------------------------------------
// pftb_pkg: shared definitions of the per-flow token bucket limiter
// Widths, register indexes, reset values and the controller command bundle.
// ----------------------------------------------------------------------------
package pftb_pkg;

  // Flow table geometry.
  localparam int FLOWS  = 256;
  localparam int FLOW_W = $clog2(FLOWS);

  // Token and time formats.
  localparam int FRAC_BITS = 16;
  localparam int TOKEN_W   = 32;
  localparam int TIME_W    = 32;
  localparam int BURST_W   = 16;
  localparam int RATE_W    = 32;
  localparam int PROD_W    = TIME_W + RATE_W;
  // Wide enough to hold the shifted burst with bits above the token width.
  localparam int CAP_WIDE_W = TOKEN_W + BURST_W;

  // One whole token in fixed point.
  localparam logic [TOKEN_W-1:0] ONE_TOKEN = TOKEN_W'(1) << FRAC_BITS;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_SIZE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE = CFG_IDX_W'(1);

  // Register reset values.
  localparam logic [BURST_W-1:0] BURST_RESET = BURST_W'(30);
  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(655);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the request and read the flow's entry
    logic multiply;  // form elapsed time times refill rate
    logic commit;    // write the bucket back and load the result register
  } pftb_cmd_t;

endpackage

[rtl/pftb_ram.sv]
// ----------------------------------------------------------------------------
// pftb_ram: generic single-write, single-read memory
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module pftb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/pftb_ctrl.sv]
// ----------------------------------------------------------------------------
// pftb_ctrl: sequencing controller
// Takes one request at a time through read, multiply and commit, and owns
// the handshakes on the request and result channels.
// ----------------------------------------------------------------------------
module pftb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output pftb_pkg::pftb_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // A request is taken only when no other is in flight.
  assign in_ready     = (state == S_IDLE);
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.multiply = (state == S_MUL);
  assign cmd.commit   = (state == S_SUM) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        if (cmd.commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/pftb_datapath.sv]
// ----------------------------------------------------------------------------
// pftb_datapath: bucket storage and refill arithmetic
// Holds the configuration registers, the per-flow tables and the result
// register, and performs the refill, saturation and token charge.
// ----------------------------------------------------------------------------
module pftb_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  pftb_pkg::pftb_cmd_t                cmd,
  input  logic                               cfg_valid,
  input  logic [pftb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pftb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [pftb_pkg::FLOW_W-1:0]        flow_index,
  input  logic [pftb_pkg::TIME_W-1:0]        now_ticks,
  output logic                               granted,
  output logic [pftb_pkg::TOKEN_W-1:0]       tokens_left
);

  logic [pftb_pkg::BURST_W-1:0]    burst_size;
  logic [pftb_pkg::RATE_W-1:0]     refill_rate;
  logic [pftb_pkg::FLOWS-1:0]      flow_seen;
  logic [pftb_pkg::FLOW_W-1:0]     flow_q;
  logic [pftb_pkg::TIME_W-1:0]     now_q;
  logic [pftb_pkg::TOKEN_W-1:0]    level_rd;
  logic [pftb_pkg::TIME_W-1:0]     time_rd;
  logic [pftb_pkg::TOKEN_W-1:0]    level_q;
  logic                            seen_q;
  logic [pftb_pkg::PROD_W-1:0]     prod_q;
  logic [pftb_pkg::TIME_W-1:0]     elapsed;
  logic [pftb_pkg::CAP_WIDE_W-1:0] cap_wide;
  logic [pftb_pkg::TOKEN_W-1:0]    capacity;
  logic [pftb_pkg::TOKEN_W:0]      sum;
  logic [pftb_pkg::TOKEN_W-1:0]    refilled;
  logic                            grant;
  logic [pftb_pkg::TOKEN_W-1:0]    level_new;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_size  <= pftb_pkg::BURST_RESET;
      refill_rate <= pftb_pkg::RATE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pftb_pkg::REG_BURST_SIZE: begin
          burst_size <= cfg_data[pftb_pkg::BURST_W-1:0];
        end
        pftb_pkg::REG_REFILL_RATE: begin
          refill_rate <= cfg_data[pftb_pkg::RATE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Per-flow level and last refill time tables.
  pftb_ram #(
    .WIDTH (pftb_pkg::TOKEN_W),
    .DEPTH (pftb_pkg::FLOWS)
  ) u_level_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (flow_q),
    .wdata (level_new),
    .re    (cmd.capture),
    .raddr (flow_index),
    .rdata (level_rd)
  );

  pftb_ram #(
    .WIDTH (pftb_pkg::TIME_W),
    .DEPTH (pftb_pkg::FLOWS)
  ) u_time_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (flow_q),
    .wdata (now_q),
    .re    (cmd.capture),
    .raddr (flow_index),
    .rdata (time_rd)
  );

  // Seen flags, cleared at reset; a flow that is not seen starts full.
  always_ff @(posedge clk) begin
    if (rst) begin
      flow_seen <= '0;
    end else if (cmd.commit) begin
      flow_seen[flow_q] <= 1'b1;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      flow_q <= flow_index;
      now_q  <= now_ticks;
    end
  end

  // Elapsed time wraps modulo the timestamp width; the product is registered.
  assign elapsed = now_q - time_rd;

  always_ff @(posedge clk) begin
    if (cmd.multiply) begin
      prod_q  <= pftb_pkg::PROD_W'(elapsed) * pftb_pkg::PROD_W'(refill_rate);
      level_q <= level_rd;
      seen_q  <= flow_seen[flow_q];
    end
  end

  // Bucket capacity, saturated to the token width.
  assign cap_wide = pftb_pkg::CAP_WIDE_W'(burst_size) << pftb_pkg::FRAC_BITS;

  always_comb begin
    if (|cap_wide[pftb_pkg::CAP_WIDE_W-1:pftb_pkg::TOKEN_W]) begin
      capacity = '1;
    end else begin
      capacity = cap_wide[pftb_pkg::TOKEN_W-1:0];
    end
  end

  // Refill with saturation at capacity, then charge one token if possible.
  assign sum = {1'b0, level_q} + {1'b0, prod_q[pftb_pkg::TOKEN_W-1:0]};

  always_comb begin
    if (!seen_q) begin
      refilled = capacity;
    end else if (|prod_q[pftb_pkg::PROD_W-1:pftb_pkg::TOKEN_W]) begin
      refilled = capacity;
    end else if (sum > {1'b0, capacity}) begin
      refilled = capacity;
    end else begin
      refilled = sum[pftb_pkg::TOKEN_W-1:0];
    end
  end

  assign grant     = (refilled >= pftb_pkg::ONE_TOKEN);
  assign level_new = grant ? (refilled - pftb_pkg::ONE_TOKEN) : refilled;

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      granted     <= grant;
      tokens_left <= level_new;
    end
  end

endmodule

[rtl/per_flow_token_bucket_limiter.sv]
// ----------------------------------------------------------------------------
// per_flow_token_bucket_limiter: token bucket policer with one bucket per flow
// Grants or refuses each request against the bucket of its flow.
// ----------------------------------------------------------------------------
// Each request names a flow and a tick timestamp and yields one result: a
// grant flag and the bucket level left, with 16 fraction bits. A flow's first
// request after reset finds its bucket full; later ones refill it by elapsed
// ticks times refill_rate, capped at burst_size tokens. A result is presented
// once its request has passed through the table read, the 32 by 32 multiply,
// and then refill and write-back. A new request is accepted on the cycle after
// the write-back, so the block takes one request at a time and accepts none
// while another is in flight. A result left waiting holds the following
// request in its final step. The configuration port is always ready;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module per_flow_token_bucket_limiter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pftb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pftb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pftb_pkg::FLOW_W-1:0]     flow_index,
  input  logic [pftb_pkg::TIME_W-1:0]     now_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            granted,
  output logic [pftb_pkg::TOKEN_W-1:0]    tokens_left
);

  pftb_pkg::pftb_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Controller.
  pftb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath.
  pftb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .flow_index  (flow_index),
    .now_ticks   (now_ticks),
    .granted     (granted),
    .tokens_left (tokens_left)
  );

  // Only one request is in flight at a time.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // The multiply step follows every accepted request.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> cmd.multiply)
    else $error("multiply step missing after request");

  // A result is never loaded over one that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // The multiply step is followed by a state that takes no new request.
  assert property (@(posedge clk) disable iff (rst)
    cmd.multiply |=> !cmd.capture && !in_ready)
    else $error("controller left the request before commit");

endmodule
